@@ hw/rtl/csc_pkg.sv @@
package csc_pkg;

	// Datapath widths.
	localparam int DW        = 32;
	localparam int ISQ_STEPS = 32;
	localparam int RW        = 34;
	localparam int CW        = 64;
	localparam int AW        = 35;
	localparam int SW        = 33;
	localparam int PRESHIFT  = 28;

	localparam logic signed [AW-1:0] HALF_TURN    = 35'sd2147483648;
	localparam logic signed [AW-1:0] QUARTER_TURN = 35'sd1073741824;
	localparam logic signed [CW-1:0] INV_GAIN     = 64'sd652032874;

	// Sideband carried alongside the square-root pipeline.
	typedef struct packed {
		logic              action;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [31:0]       rmag;
		logic [31:0]       pol;
		logic [31:0]       az;
		logic              zero_az;
		logic              zero_pol;
	} side_a_t;

	// Sideband carried alongside the CORDIC pipeline and the tail.
	typedef struct packed {
		logic              action;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [32:0]       radius;
		logic [31:0]       pol;
		logic [31:0]       az;
		logic              zero_az;
		logic              zero_pol;
		logic              neg_p;
		logic              neg_a;
	} side_b_t;

	typedef struct packed {
		logic signed [AW-1:0] ang;
		logic                 neg;
	} rot_t;

	// Arctangent of 2^-k in binary-angle units.
	function automatic logic [31:0] atan_at(input int k);
		logic [31:0] a;
		unique case (k)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// Fold a binary angle into the right half plane for the rotation CORDIC.
	function automatic rot_t rot_prep(input logic [31:0] a);
		rot_t r;
		logic signed [AW-1:0] z;
		z = $signed({{(AW-32){a[31]}}, a});
		r.ang = z;
		r.neg = 1'b0;
		if (z > QUARTER_TURN) begin
			r.ang = z - HALF_TURN;
			r.neg = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			r.ang = z + HALF_TURN;
			r.neg = 1'b1;
		end
		return r;
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [39:0] v);
		logic [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cartesian_spherical_converter.sv @@
// Channel | Handshake             | Payload
// input   | in_valid / in_ready   | action, in_x, in_y, in_z, in_radius, in_polar, in_azimuth
// output  | out_valid / out_ready | out_x, out_y, out_z, out_radius, out_polar, out_azimuth
//
// One item enters per cycle while the pipeline is not stalled.
// Items pass through the 32-stage square-root pipeline followed by the CORDIC stages.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances together: it holds when the output stage is full and not taken.
module cartesian_spherical_converter #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic signed [31:0] in_radius,
	input  logic [31:0]        in_polar,
	input  logic [31:0]        in_azimuth,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [32:0]        out_radius,
	output logic [31:0]        out_polar,
	output logic [31:0]        out_azimuth
);

	localparam int ISQ = csc_pkg::ISQ_STEPS;
	localparam int CW  = csc_pkg::CW;
	localparam int AW  = csc_pkg::AW;
	localparam int SW  = csc_pkg::SW;
	localparam int RW  = csc_pkg::RW;
	localparam int PS  = csc_pkg::PRESHIFT;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic isq_v_s [ISQ];
	logic cb_v_s  [CORDIC_STEPS];

	// Pipeline advances unless a finished result is waiting.
	assign en       = !v_s8 || out_ready;
	assign in_ready = en;

	// Stage 1: squares and spherical normalization.
	logic signed [63:0] sq_x, sq_y, sq_z;
	logic [31:0]        pol_f;
	csc_pkg::side_a_t   sa_in;

	assign sq_x = 64'(in_x) * 64'(in_x);
	assign sq_y = 64'(in_y) * 64'(in_y);
	assign sq_z = 64'(in_z) * 64'(in_z);

	always_comb begin
		pol_f = in_polar[31] ? (32'd0 - in_polar) : in_polar;
		sa_in.action   = action;
		sa_in.x        = in_x;
		sa_in.y        = in_y;
		sa_in.z        = in_z;
		sa_in.rmag     = $unsigned(in_radius);
		sa_in.pol      = pol_f;
		sa_in.az       = in_azimuth;
		sa_in.zero_az  = (in_x == 32'sd0) && (in_y == 32'sd0);
		sa_in.zero_pol = (in_x == 32'sd0) && (in_y == 32'sd0) && (in_z == 32'sd0);
		if (in_radius[31]) begin
			sa_in.rmag = 32'd0 - $unsigned(in_radius);
			sa_in.pol  = 32'h8000_0000 - pol_f;
			sa_in.az   = in_azimuth + 32'h8000_0000;
		end
	end

	logic [63:0]      xx_s1, yy_s1, zz_s1;
	csc_pkg::side_a_t sd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= $unsigned(sq_x);
			yy_s1 <= $unsigned(sq_y);
			zz_s1 <= $unsigned(sq_z);
			sd_s1 <= sa_in;
		end
	end

	// Stage 2: sums of squares.
	logic [63:0]      nr_s2, nrho_s2;
	csc_pkg::side_a_t sd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s2   <= xx_s1 + yy_s1 + zz_s1;
			nrho_s2 <= xx_s1 + yy_s1;
			sd_s2   <= sd_s1;
		end
	end

	// Square roots of both sums.
	logic [31:0]   r_root, rho_root;
	logic [RW-1:0] r_rem, rho_rem;

	csc_isqrt u_isq_r (
		.clk  (clk),
		.en   (en),
		.n    (nr_s2),
		.root (r_root),
		.rem  (r_rem)
	);

	csc_isqrt u_isq_rho (
		.clk  (clk),
		.en   (en),
		.n    (nrho_s2),
		.root (rho_root),
		.rem  (rho_rem)
	);

	csc_pkg::side_a_t isq_side_s [ISQ];

	always_ff @(posedge clk) begin
		if (en) begin
			isq_side_s[0] <= sd_s2;
			for (int i = 1; i < ISQ; i++) begin
				isq_side_s[i] <= isq_side_s[i-1];
			end
		end
	end

	// Stage 3: rounding and CORDIC setup.
	csc_pkg::side_a_t     sd_a;
	csc_pkg::side_b_t     sb_in;
	csc_pkg::rot_t        rp, ra;
	logic [32:0]          rad, rho;
	logic signed [CW-1:0] ax0, ay0, bx0, by0;
	logic signed [AW-1:0] az0, bz0;

	always_comb begin
		sd_a = isq_side_s[ISQ-1];
		rad  = 33'(r_root) + 33'(r_rem > RW'(r_root));
		rho  = 33'(rho_root) + 33'(rho_rem > RW'(rho_root));
		rp   = csc_pkg::rot_prep(sd_a.pol);
		ra   = csc_pkg::rot_prep(sd_a.az);
		if (sd_a.action) begin
			ax0 = csc_pkg::INV_GAIN;
			ay0 = '0;
			az0 = rp.ang;
			bx0 = csc_pkg::INV_GAIN;
			by0 = '0;
			bz0 = ra.ang;
		end else begin
			ax0 = CW'(sd_a.z) <<< PS;
			ay0 = $signed(CW'(rho)) <<< PS;
			az0 = '0;
			if (sd_a.z[31]) begin
				ax0 = -ax0;
				ay0 = -ay0;
				az0 = csc_pkg::HALF_TURN;
			end
			bx0 = CW'(sd_a.x) <<< PS;
			by0 = CW'(sd_a.y) <<< PS;
			bz0 = '0;
			if (sd_a.x[31]) begin
				bx0 = -bx0;
				by0 = -by0;
				bz0 = csc_pkg::HALF_TURN;
			end
		end
		sb_in.action   = sd_a.action;
		sb_in.x        = sd_a.x;
		sb_in.y        = sd_a.y;
		sb_in.z        = sd_a.z;
		sb_in.radius   = sd_a.action ? {1'b0, sd_a.rmag} : rad;
		sb_in.pol      = sd_a.pol;
		sb_in.az       = sd_a.az;
		sb_in.zero_az  = sd_a.zero_az;
		sb_in.zero_pol = sd_a.zero_pol;
		sb_in.neg_p    = rp.neg;
		sb_in.neg_a    = ra.neg;
	end

	logic signed [CW-1:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic signed [AW-1:0] az_s3, bz_s3;
	csc_pkg::side_b_t     sd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3 <= ax0;
			ay_s3 <= ay0;
			az_s3 <= az0;
			bx_s3 <= bx0;
			by_s3 <= by0;
			bz_s3 <= bz0;
			sd_s3 <= sb_in;
		end
	end

	// Unit A: polar vectoring or polar sine and cosine. Unit B: the same for azimuth.
	logic signed [CW-1:0] axo, ayo, bxo, byo;
	logic signed [AW-1:0] azo, bzo;

	csc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
		.clk (clk),
		.en  (en),
		.vec (!sd_s3.action),
		.x0  (ax_s3),
		.y0  (ay_s3),
		.z0  (az_s3),
		.xo  (axo),
		.yo  (ayo),
		.zo  (azo)
	);

	csc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
		.clk (clk),
		.en  (en),
		.vec (!sd_s3.action),
		.x0  (bx_s3),
		.y0  (by_s3),
		.z0  (bz_s3),
		.xo  (bxo),
		.yo  (byo),
		.zo  (bzo)
	);

	csc_pkg::side_b_t cb_side_s [CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			cb_side_s[0] <= sd_s3;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				cb_side_s[i] <= cb_side_s[i-1];
			end
		end
	end

	// Stage 4: angle clamping and sine/cosine sign fix.
	csc_pkg::side_b_t     sb_post;
	logic signed [CW-1:0] cp_w, sp_w, ca_w, sa_w;

	always_comb begin
		sb_post = cb_side_s[CORDIC_STEPS-1];
		cp_w    = sb_post.neg_p ? -axo : axo;
		sp_w    = sb_post.neg_p ? -ayo : ayo;
		ca_w    = sb_post.neg_a ? -bxo : bxo;
		sa_w    = sb_post.neg_a ? -byo : byo;
		if (!sb_post.action) begin
			if (sb_post.zero_pol || azo[AW-1]) begin
				sb_post.pol = '0;
			end else if (azo > csc_pkg::HALF_TURN) begin
				sb_post.pol = 32'h8000_0000;
			end else begin
				sb_post.pol = azo[31:0];
			end
			sb_post.az = sb_post.zero_az ? 32'd0 : bzo[31:0];
		end
	end

	logic signed [SW-1:0] cp_s4, sp_s4, ca_s4, sa_s4;
	csc_pkg::side_b_t     sd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s4 <= SW'(cp_w);
			sp_s4 <= SW'(sp_w);
			ca_s4 <= SW'(ca_w);
			sa_s4 <= SW'(sa_w);
			sd_s4 <= sb_post;
		end
	end

	// Stage 5: radius times sine and cosine of the polar angle.
	logic signed [32:0]   rs_w;
	logic signed [65:0]   pt_s5, pz_s5;
	logic signed [SW-1:0] ca_s5, sa_s5;
	csc_pkg::side_b_t     sd_s5;

	assign rs_w = $signed({1'b0, sd_s4.radius[31:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s5 <= 66'(rs_w) * 66'(sp_s4);
			pz_s5 <= 66'(rs_w) * 66'(cp_s4);
			ca_s5 <= ca_s4;
			sa_s5 <= sa_s4;
			sd_s5 <= sd_s4;
		end
	end

	// Stage 6: round both products to Q16.16.
	logic signed [65:0]   pt_rnd, pz_rnd;
	logic signed [35:0]   t_s6, zr_s6;
	logic signed [SW-1:0] ca_s6, sa_s6;
	csc_pkg::side_b_t     sd_s6;

	assign pt_rnd = (pt_s5 + 66'sd536870912) >>> 30;
	assign pz_rnd = (pz_s5 + 66'sd536870912) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s6  <= 36'(pt_rnd);
			zr_s6 <= 36'(pz_rnd);
			ca_s6 <= ca_s5;
			sa_s6 <= sa_s5;
			sd_s6 <= sd_s5;
		end
	end

	// Stage 7: azimuth products.
	logic signed [68:0] px_s7, py_s7;
	logic signed [35:0] zr_s7;
	csc_pkg::side_b_t   sd_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s7 <= 69'(t_s6) * 69'(ca_s6);
			py_s7 <= 69'(t_s6) * 69'(sa_s6);
			zr_s7 <= zr_s6;
			sd_s7 <= sd_s6;
		end
	end

	// Stage 8: round, saturate and pick the outputs by direction.
	logic signed [68:0] px_rnd, py_rnd;
	logic [31:0]        x_f, y_f, z_f;

	assign px_rnd = (px_s7 + 69'sd536870912) >>> 30;
	assign py_rnd = (py_s7 + 69'sd536870912) >>> 30;

	always_comb begin
		if (sd_s7.action) begin
			x_f = csc_pkg::sat32(40'(px_rnd));
			y_f = csc_pkg::sat32(40'(py_rnd));
			z_f = csc_pkg::sat32(40'(zr_s7));
		end else begin
			x_f = $unsigned(sd_s7.x);
			y_f = $unsigned(sd_s7.y);
			z_f = $unsigned(sd_s7.z);
		end
	end

	logic [31:0] ox_s8, oy_s8, oz_s8, op_s8, oa_s8;
	logic [32:0] or_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s8 <= x_f;
			oy_s8 <= y_f;
			oz_s8 <= z_f;
			or_s8 <= sd_s7.radius;
			op_s8 <= sd_s7.pol;
			oa_s8 <= sd_s7.az;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			for (int i = 0; i < ISQ; i++) begin
				isq_v_s[i] <= 1'b0;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				cb_v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1       <= in_valid;
			v_s2       <= v_s1;
			isq_v_s[0] <= v_s2;
			for (int i = 1; i < ISQ; i++) begin
				isq_v_s[i] <= isq_v_s[i-1];
			end
			v_s3      <= isq_v_s[ISQ-1];
			cb_v_s[0] <= v_s3;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				cb_v_s[i] <= cb_v_s[i-1];
			end
			v_s4 <= cb_v_s[CORDIC_STEPS-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	assign out_valid   = v_s8;
	assign out_x       = $signed(ox_s8);
	assign out_y       = $signed(oy_s8);
	assign out_z       = $signed(oz_s8);
	assign out_radius  = or_s8;
	assign out_polar   = op_s8;
	assign out_azimuth = oa_s8;

`ifndef ASSERT_OFF
	// A result can only appear if the stage before held one.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s7))
		else $error("output valid rose without an item in the last stage");

	// The polar angle never leaves [0, half turn].
	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_polar <= 32'h8000_0000))
		else $error("polar angle out of range");

	// A waiting result stalls the input side.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while the pipeline is stalled");
`endif

endmodule

@@ hw/rtl/csc_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module csc_isqrt (
	input  logic                     clk,
	input  logic                     en,
	input  logic [63:0]              n,
	output logic [31:0]              root,
	output logic [csc_pkg::RW-1:0]   rem
);

	localparam int N  = csc_pkg::ISQ_STEPS;
	localparam int RW = csc_pkg::RW;

	logic [31:0]   root_s [N];
	logic [RW-1:0] rem_s  [N];
	logic [63:0]   n_s    [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [31:0]   q_in;
		logic [RW-1:0] r_in;
		logic [63:0]   n_in;
		logic [RW+1:0] acc;
		logic [RW+1:0] trial;

		if (k == 0) begin : g_first
			assign q_in = '0;
			assign r_in = '0;
			assign n_in = n;
		end else begin : g_next
			assign q_in = root_s[k-1];
			assign r_in = rem_s[k-1];
			assign n_in = n_s[k-1];
		end

		// Bring down two bits and try the next root bit.
		assign acc   = {r_in, n_in[63:62]};
		assign trial = {{(RW-32){1'b0}}, q_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (acc >= trial) begin
					rem_s[k]  <= RW'(acc - trial);
					root_s[k] <= {q_in[30:0], 1'b1};
				end else begin
					rem_s[k]  <= acc[RW-1:0];
					root_s[k] <= {q_in[30:0], 1'b0};
				end
				n_s[k] <= {n_in[61:0], 2'b00};
			end
		end
	end

	assign root = root_s[N-1];
	assign rem  = rem_s[N-1];

endmodule

@@ hw/rtl/csc_cordic.sv @@
// Pipelined CORDIC, one micro-rotation per stage; each item selects vectoring or rotation.
module csc_cordic #(
	parameter int STEPS = 24
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           vec,
	input  logic signed [csc_pkg::CW-1:0]  x0,
	input  logic signed [csc_pkg::CW-1:0]  y0,
	input  logic signed [csc_pkg::AW-1:0]  z0,
	output logic signed [csc_pkg::CW-1:0]  xo,
	output logic signed [csc_pkg::CW-1:0]  yo,
	output logic signed [csc_pkg::AW-1:0]  zo
);

	localparam int CW = csc_pkg::CW;
	localparam int AW = csc_pkg::AW;

	logic signed [CW-1:0] x_s   [STEPS];
	logic signed [CW-1:0] y_s   [STEPS];
	logic signed [AW-1:0] z_s   [STEPS];
	logic                 vec_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [AW-1:0] zi;
		logic signed [AW-1:0] da;
		logic                 vi;
		logic                 pos;

		if (k == 0) begin : g_first
			assign xi = x0;
			assign yi = y0;
			assign zi = z0;
			assign vi = vec;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
			assign vi = vec_s[k-1];
		end

		assign dx = yi >>> k;
		assign dy = xi >>> k;
		assign da = $signed({{(AW-32){1'b0}}, csc_pkg::atan_at(k)});

		// Vectoring drives y toward zero; rotation drives the angle toward zero.
		assign pos = vi ? !yi[CW-1] : zi[AW-1];

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k] <= vi;
				if (pos) begin
					x_s[k] <= xi + dx;
					y_s[k] <= yi - dy;
					z_s[k] <= zi + da;
				end else begin
					x_s[k] <= xi - dx;
					y_s[k] <= yi + dy;
					z_s[k] <= zi - da;
				end
			end
		end
	end

	assign xo = x_s[STEPS-1];
	assign yo = y_s[STEPS-1];
	assign zo = z_s[STEPS-1];

endmodule
